>>> rtl/mhaa_pkg.sv
`timescale 1ns / 1ps

package mhaa_pkg;

    // Sizes of the block
    localparam int MAX_CLASSIFIERS = 32;
    localparam int MAX_CLASSES     = 256;
    localparam int SCORE_W         = 16;
    localparam int CLASS_W         = 8;
    localparam int CLSF_W          = 5;
    localparam int COUNT_W         = 16;
    localparam int ACC_W           = 17;
    localparam int NC_W            = 9;
    localparam int NK_W            = 6;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 9;

    // Saturation and full-scale values
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [ACC_W-1:0]   ACC_ONE   = 17'h10000;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_CLASS_COUNT      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CLASSIFIER_COUNT = 2'd1;

    // Sequencer states
    typedef enum logic [6:0] {
        S_CLEAR     = 7'b0000001,
        S_RUN       = 7'b0000010,
        S_HIT       = 7'b0000100,
        S_EMIT_RD   = 7'b0001000,
        S_EMIT_CALC = 7'b0010000,
        S_EMIT_DIV  = 7'b0100000,
        S_EMIT_PUSH = 7'b1000000
    } state_t;

    // Divider request and status
    typedef struct packed {
        logic               start;
        logic [COUNT_W-1:0] dividend;
        logic [COUNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic [COUNT_W-1:0] quotient;
    } div_status_t;

endpackage

>>> rtl/mhaa_div.sv
`timescale 1ns / 1ps

// Restoring divider: quotient = floor(dividend * 2^16 / divisor),
// for dividend below divisor. One quotient bit per cycle.
module mhaa_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mhaa_pkg::div_req_t   req,
    output mhaa_pkg::div_status_t status
);

    logic [mhaa_pkg::COUNT_W-1:0] rem_reg;
    logic [mhaa_pkg::COUNT_W-1:0] rem_next;
    logic [mhaa_pkg::COUNT_W-1:0] quo_reg;
    logic [mhaa_pkg::COUNT_W-1:0] quo_next;
    logic [mhaa_pkg::COUNT_W-1:0] div_reg;
    logic [mhaa_pkg::COUNT_W-1:0] div_next;
    logic [4:0]                   cnt_reg;
    logic [4:0]                   cnt_next;
    logic [mhaa_pkg::COUNT_W:0]   shifted;
    logic                         fits;

    // Shift the partial remainder and try a subtract; the remainder stays
    // below the divisor, so it always fits back in COUNT_W bits
    assign shifted = {rem_reg, 1'b0};
    assign fits    = shifted >= {1'b0, div_reg};

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        div_next = div_reg;
        cnt_next = cnt_reg;
        if (req.start)
        begin
            rem_next = req.dividend;
            quo_next = '0;
            div_next = req.divisor;
            cnt_next = 5'(mhaa_pkg::COUNT_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next = fits ? 16'(shifted - {1'b0, div_reg}) :
                       shifted[mhaa_pkg::COUNT_W-1:0];
            quo_next = {quo_reg[mhaa_pkg::COUNT_W-2:0], fits};
            cnt_next = cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign status = {(cnt_reg != '0), quo_reg};

endmodule

>>> rtl/multi_head_argmax_accuracy_top.sv
`timescale 1ns / 1ps

// Top-1 accuracy over several classifier heads.
// Input channel (in_valid / in_stall): one class score per request, with the
// label and end_of_batch. Scores come sample by sample, classifier by
// classifier, class by class. One request is taken per cycle while the input
// is not stalled; a window's last score that matches the label stalls it for
// the read-modify-write of the per-classifier hit counter in the hit memory.
// Output channel (out_valid / out_stall): after a request with end_of_batch,
// one result per classifier in classifier order, last_result on the final
// one. The emission sweeps all 32 hit memory entries, clearing each; every
// entry passes S_EMIT_RD, S_EMIT_CALC, S_EMIT_DIV and S_EMIT_PUSH, and an
// active classifier that needs a division waits on the shared divider in
// S_EMIT_DIV. The input stalls during the sweep. The first result is loaded
// into the output register in S_EMIT_PUSH, after S_HIT on a hit.
// A stalled output holds its request; the sweep waits on it, and once all
// 32 entries are swept new scores are taken again.
// Config port (cfg_valid / cfg_ready): index 0 class_count, index 1
// classifier_count; ready only while scores are taken, so a write waits out
// the emission sweep.
// Reset: registers return to class_count 2, classifier_count 1, and a
// clearing pass zeroes all 32 hit memory entries before scores are taken.
module multi_head_argmax_accuracy_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [mhaa_pkg::SCORE_W-1:0]  score,
    input  logic [mhaa_pkg::CLASS_W-1:0]         label,
    input  logic                                 end_of_batch,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [mhaa_pkg::CLSF_W-1:0]          classifier_index,
    output logic [mhaa_pkg::COUNT_W-1:0]         hit_count,
    output logic [mhaa_pkg::ACC_W-1:0]           accuracy,
    output logic                                 last_result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mhaa_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mhaa_pkg::CFG_DATA_W-1:0]      cfg_data
);

    mhaa_pkg::state_t state_reg;
    mhaa_pkg::state_t state_next;

    logic [mhaa_pkg::NC_W-1:0]     class_count_reg;
    logic [mhaa_pkg::NK_W-1:0]     classifier_count_reg;

    logic signed [mhaa_pkg::SCORE_W-1:0] best_score_reg;
    logic signed [mhaa_pkg::SCORE_W-1:0] best_score_next;
    logic [mhaa_pkg::CLASS_W-1:0]  best_class_reg;
    logic [mhaa_pkg::CLASS_W-1:0]  best_class_next;
    logic [mhaa_pkg::CLASS_W-1:0]  class_position_reg;
    logic [mhaa_pkg::CLASS_W-1:0]  class_position_next;
    logic [mhaa_pkg::CLSF_W-1:0]   classifier_position_reg;
    logic [mhaa_pkg::CLSF_W-1:0]   classifier_position_next;
    logic [mhaa_pkg::COUNT_W-1:0]  sample_total_reg;
    logic [mhaa_pkg::COUNT_W-1:0]  sample_total_next;

    logic [mhaa_pkg::CLSF_W-1:0]   hit_addr_reg;
    logic [mhaa_pkg::CLSF_W-1:0]   hit_addr_next;
    logic                          eob_pend_reg;
    logic                          eob_pend_next;
    logic [mhaa_pkg::CLSF_W-1:0]   sweep_reg;
    logic [mhaa_pkg::CLSF_W-1:0]   sweep_next;
    logic [mhaa_pkg::COUNT_W-1:0]  hits_reg;
    logic [mhaa_pkg::COUNT_W-1:0]  hits_next;
    logic                          need_div_reg;
    logic                          need_div_next;
    logic [mhaa_pkg::ACC_W-1:0]    acc_reg;
    logic [mhaa_pkg::ACC_W-1:0]    acc_next;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [mhaa_pkg::CLSF_W-1:0]   out_index_reg;
    logic [mhaa_pkg::COUNT_W-1:0]  out_hits_reg;
    logic [mhaa_pkg::ACC_W-1:0]    out_acc_reg;
    logic                          out_last_reg;
    logic                          out_load;

    // Hit memory, one entry per classifier
    logic [mhaa_pkg::COUNT_W-1:0]  hit_mem [mhaa_pkg::MAX_CLASSIFIERS];
    logic [mhaa_pkg::COUNT_W-1:0]  rd_data_reg;
    logic [mhaa_pkg::CLSF_W-1:0]   rd_addr;
    logic                          wr_en;
    logic [mhaa_pkg::CLSF_W-1:0]   wr_addr;
    logic [mhaa_pkg::COUNT_W-1:0]  wr_data;

    logic [mhaa_pkg::NC_W-1:0]     nc_eff;
    logic [mhaa_pkg::NK_W-1:0]     nk_eff;
    logic                          accept;
    logic                          take;
    logic [mhaa_pkg::CLASS_W-1:0]  step_best_class;
    logic                          win_end;
    logic                          sample_end;
    logic                          step_hit;
    logic                          sweep_last;
    logic                          sweep_active;
    logic                          out_free;

    mhaa_pkg::div_req_t            div_req;
    mhaa_pkg::div_status_t         div_status;

    // Clamp the registers to their legal ranges
    always_comb
    begin
        if (class_count_reg == '0)
            nc_eff = 9'd1;
        else if (class_count_reg > 9'(mhaa_pkg::MAX_CLASSES))
            nc_eff = 9'(mhaa_pkg::MAX_CLASSES);
        else
            nc_eff = class_count_reg;

        if (classifier_count_reg == '0)
            nk_eff = 6'd1;
        else if (classifier_count_reg > 6'(mhaa_pkg::MAX_CLASSIFIERS))
            nk_eff = 6'(mhaa_pkg::MAX_CLASSIFIERS);
        else
            nk_eff = classifier_count_reg;
    end

    // Arg-max step and window bookkeeping
    assign accept          = in_valid && (state_reg == mhaa_pkg::S_RUN);
    assign take            = (class_position_reg == '0) || (score > best_score_reg);
    assign step_best_class = take ? class_position_reg : best_class_reg;
    assign win_end         = ({1'b0, class_position_reg} + 9'd1) >= nc_eff;
    assign sample_end      = ({1'b0, classifier_position_reg} + 6'd1) >= nk_eff;
    assign step_hit        = win_end && (step_best_class == label);

    assign sweep_last   = sweep_reg == 5'(mhaa_pkg::MAX_CLASSIFIERS - 1);
    assign sweep_active = {1'b0, sweep_reg} < nk_eff;
    assign out_free     = !out_valid_reg || !out_stall;

    // Sequencer
    always_comb
    begin
        state_next               = state_reg;
        best_score_next          = best_score_reg;
        best_class_next          = best_class_reg;
        class_position_next      = class_position_reg;
        classifier_position_next = classifier_position_reg;
        sample_total_next        = sample_total_reg;
        hit_addr_next            = hit_addr_reg;
        eob_pend_next            = eob_pend_reg;
        sweep_next               = sweep_reg;
        hits_next                = hits_reg;
        need_div_next            = need_div_reg;
        acc_next                 = acc_reg;
        out_load                 = 1'b0;
        wr_en                    = 1'b0;
        wr_addr                  = sweep_reg;
        wr_data                  = '0;
        div_req.start            = 1'b0;
        div_req.dividend         = rd_data_reg;
        div_req.divisor          = sample_total_reg;

        case (state_reg)
            mhaa_pkg::S_CLEAR:
            begin
                // Zero one entry per cycle
                wr_en      = 1'b1;
                sweep_next = sweep_reg + 5'd1;
                if (sweep_last)
                    state_next = mhaa_pkg::S_RUN;
            end
            mhaa_pkg::S_RUN:
            begin
                if (accept)
                begin
                    best_score_next = take ? score : best_score_reg;
                    best_class_next = step_best_class;
                    hit_addr_next   = classifier_position_reg;
                    eob_pend_next   = end_of_batch;
                    sweep_next      = '0;
                    if (win_end)
                    begin
                        class_position_next = '0;
                        if (sample_end)
                        begin
                            classifier_position_next = '0;
                            if (sample_total_reg != mhaa_pkg::COUNT_MAX)
                                sample_total_next = sample_total_reg + 16'd1;
                        end
                        else
                        begin
                            classifier_position_next = classifier_position_reg + 5'd1;
                        end
                    end
                    else
                    begin
                        class_position_next = class_position_reg + 8'd1;
                    end
                    if (step_hit)
                        state_next = mhaa_pkg::S_HIT;
                    else if (end_of_batch)
                        state_next = mhaa_pkg::S_EMIT_RD;
                end
            end
            mhaa_pkg::S_HIT:
            begin
                // Write back the incremented, saturating hit count
                wr_en   = 1'b1;
                wr_addr = hit_addr_reg;
                wr_data = (rd_data_reg == mhaa_pkg::COUNT_MAX) ?
                          rd_data_reg : rd_data_reg + 16'd1;
                state_next = eob_pend_reg ? mhaa_pkg::S_EMIT_RD : mhaa_pkg::S_RUN;
            end
            mhaa_pkg::S_EMIT_RD:
            begin
                state_next = mhaa_pkg::S_EMIT_CALC;
            end
            mhaa_pkg::S_EMIT_CALC:
            begin
                // Take the count, clear the entry, pick the accuracy path
                wr_en     = 1'b1;
                hits_next = rd_data_reg;
                need_div_next = 1'b0;
                if (sample_total_reg == '0)
                    acc_next = '0;
                else if (rd_data_reg >= sample_total_reg)
                    acc_next = mhaa_pkg::ACC_ONE;
                else
                    need_div_next = 1'b1;
                div_req.start = sweep_active && (sample_total_reg != '0) &&
                                (rd_data_reg < sample_total_reg);
                state_next = mhaa_pkg::S_EMIT_DIV;
            end
            mhaa_pkg::S_EMIT_DIV:
            begin
                if (!div_status.busy)
                begin
                    if (need_div_reg)
                        acc_next = {1'b0, div_status.quotient};
                    state_next = mhaa_pkg::S_EMIT_PUSH;
                end
            end
            mhaa_pkg::S_EMIT_PUSH:
            begin
                if (!sweep_active || out_free)
                begin
                    out_load   = sweep_active;
                    sweep_next = sweep_reg + 5'd1;
                    if (sweep_last)
                    begin
                        // Drop the partial window and all counts
                        best_score_next          = '0;
                        best_class_next          = '0;
                        class_position_next      = '0;
                        classifier_position_next = '0;
                        sample_total_next        = '0;
                        eob_pend_next            = 1'b0;
                        state_next               = mhaa_pkg::S_RUN;
                    end
                    else
                    begin
                        state_next = mhaa_pkg::S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = mhaa_pkg::S_CLEAR;
            end
        endcase
    end

    assign rd_addr = (state_reg == mhaa_pkg::S_EMIT_RD) ? sweep_reg : classifier_position_reg;

    // Hit memory ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
            hit_mem[wr_addr] <= wr_data;
        rd_data_reg <= hit_mem[rd_addr];
    end

    // Shared divider
    mhaa_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (div_req),
        .status (div_status)
    );

    assign out_valid_next = out_load || (out_valid_reg && out_stall);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg               <= mhaa_pkg::S_CLEAR;
            class_count_reg         <= 9'd2;
            classifier_count_reg    <= 6'd1;
            best_score_reg          <= '0;
            best_class_reg          <= '0;
            class_position_reg      <= '0;
            classifier_position_reg <= '0;
            sample_total_reg        <= '0;
            eob_pend_reg            <= 1'b0;
            sweep_reg               <= '0;
            out_valid_reg           <= 1'b0;
        end
        else
        begin
            state_reg               <= state_next;
            best_score_reg          <= best_score_next;
            best_class_reg          <= best_class_next;
            class_position_reg      <= class_position_next;
            classifier_position_reg <= classifier_position_next;
            sample_total_reg        <= sample_total_next;
            eob_pend_reg            <= eob_pend_next;
            sweep_reg               <= sweep_next;
            out_valid_reg           <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == mhaa_pkg::REG_CLASS_COUNT)
                    class_count_reg <= cfg_data;
                else if (cfg_index == mhaa_pkg::REG_CLASSIFIER_COUNT)
                    classifier_count_reg <= cfg_data[mhaa_pkg::NK_W-1:0];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        hit_addr_reg <= hit_addr_next;
        hits_reg     <= hits_next;
        need_div_reg <= need_div_next;
        acc_reg      <= acc_next;
        if (out_load)
        begin
            out_index_reg <= sweep_reg;
            out_hits_reg  <= hits_reg;
            out_acc_reg   <= acc_reg;
            out_last_reg  <= ({1'b0, sweep_reg} + 6'd1) == nk_eff;
        end
    end

    assign in_stall         = state_reg != mhaa_pkg::S_RUN;
    assign cfg_ready        = state_reg == mhaa_pkg::S_RUN;
    assign out_valid        = out_valid_reg;
    assign classifier_index = out_index_reg;
    assign hit_count        = out_hits_reg;
    assign accuracy         = out_acc_reg;
    assign last_result      = out_last_reg;

    // The counter write-back only follows an accepted score
    a_hit_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mhaa_pkg::S_HIT) |-> $past(in_valid && !in_stall))
        else $error("hit write-back without an accepted score");

    // The divider is never restarted while it runs
    a_div_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_status.busy)
        else $error("divider started while busy");

    // The final result carries the last active classifier index
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |->
        (({1'b0, out_index_reg} + 6'd1) == nk_eff))
        else $error("last result on wrong classifier");

    // A loaded result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result overwritten while stalled");

endmodule
